### hdl/assert_macros.svh
// assertion macros shared by the led blink controller rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define LBPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define LBPC_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

### hdl/lbpc_pkg.sv
// types and constants for the led blink controller
// no dependencies
`timescale 1ns / 1ps

package lbpc_pkg;

  localparam int TIME_W  = 32;
  localparam int CYC_W   = 7;
  localparam int DUTY_W  = 17;
  localparam int PROD_W  = TIME_W + DUTY_W;
  localparam int FRAC_W  = 16;

  localparam logic [DUTY_W-1:0] DUTY_ONE = DUTY_W'(1) << FRAC_W;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_ON         = 3'd1,
    CMD_OFF        = 3'd2,
    CMD_OFF_BLINK  = 3'd3,
    CMD_PULSE      = 3'd4,
    CMD_BLINK      = 3'd5,
    CMD_BLINK_DUTY = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FIXED = 2'd1,
    MODE_PULSE = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  // prepared transaction handed to the state stage
  typedef struct packed {
    logic [2:0]        cmd;
    logic [TIME_W-1:0] time_a;
    logic [TIME_W-1:0] on_t;
    logic [TIME_W-1:0] off_t;
    logic [CYC_W-1:0]  cyc;
  } item_t;

endpackage

### hdl/lbpc_prep.sv
// input register and blink time preparation (duty multiply)
// depends on lbpc_pkg
`timescale 1ns / 1ps

module lbpc_prep import lbpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_cmd,
  input  logic [31:0]       in_time_a,
  input  logic [31:0]       in_time_b,
  input  logic [6:0]        in_cycle_count,
  input  logic [16:0]       in_duty,
  output logic              item_valid,
  input  logic              item_ready,
  output item_t             item
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [2:0]        s1_cmd_r;
  logic [TIME_W-1:0] s1_ta_r;
  logic [TIME_W-1:0] s1_tb_r;
  logic [CYC_W-1:0]  s1_cyc_r;
  logic [DUTY_W-1:0] s1_duty_r;

  logic              s2_valid_r, s2_valid_nxt;
  item_t             s2_item_r, s2_item_nxt;

  logic              s1_ready;
  logic              s2_ready;
  logic [DUTY_W-1:0] duty_c;
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] mul_on;

  assign s2_ready = !s2_valid_r || item_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  assign s1_valid_nxt = s1_ready ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;

  // duty above one is clamped to one
  assign duty_c = s1_duty_r[FRAC_W] ? DUTY_ONE : s1_duty_r;
  assign prod   = PROD_W'(s1_ta_r) * PROD_W'(duty_c);
  assign mul_on = prod[TIME_W+FRAC_W-1:FRAC_W];

  always_comb begin
    s2_item_nxt.cmd    = s1_cmd_r;
    s2_item_nxt.time_a = s1_ta_r;
    s2_item_nxt.cyc    = s1_cyc_r;
    if (s1_cmd_r == CMD_BLINK) begin
      s2_item_nxt.on_t  = s1_ta_r;
      s2_item_nxt.off_t = s1_tb_r;
    end else begin
      s2_item_nxt.on_t  = mul_on;
      s2_item_nxt.off_t = s1_ta_r - mul_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_cmd_r  <= in_cmd;
      s1_ta_r   <= in_time_a[TIME_W-1:0];
      s1_tb_r   <= in_time_b[TIME_W-1:0];
      s1_cyc_r  <= in_cycle_count;
      s1_duty_r <= in_duty;
    end
    if (s1_valid_r && s2_ready) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign item_valid = s2_valid_r;
  assign item       = s2_item_r;

endmodule

### hdl/lbpc_core.sv
// led state (mode, lamp, timers) and the result register
// depends on lbpc_pkg
`timescale 1ns / 1ps

module lbpc_core import lbpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  input  logic             active_level,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_pin_level,
  output logic             out_lit,
  output logic [1:0]       out_mode,
  output logic [6:0]       out_cycles_left
);

  mode_t             mode_r, mode_nxt;
  logic              counted_r, counted_nxt;
  logic              lamp_r, lamp_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0] pulse_len_r, pulse_len_nxt;
  logic [TIME_W-1:0] on_len_r, on_len_nxt;
  logic [TIME_W-1:0] off_len_r, off_len_nxt;
  logic [CYC_W-1:0]  rem_r, rem_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              pin_r, pin_nxt;
  logic              lit_r, lit_nxt;
  logic [1:0]        omode_r, omode_nxt;
  logic [CYC_W-1:0]  ocyc_r, ocyc_nxt;

  logic              take;
  logic [TIME_W-1:0] el_inc;
  logic [CYC_W-1:0]  rem_dec;

  assign item_ready    = !out_valid_r || !out_stall;
  assign take          = item_valid && item_ready;
  assign out_valid_nxt = take ? 1'b1 : (out_valid_r && out_stall);

  // saturating tick count
  assign el_inc  = (elapsed_r != {TIME_W{1'b1}}) ? elapsed_r + TIME_W'(1) : elapsed_r;
  assign rem_dec = (rem_r != '0) ? rem_r - CYC_W'(1) : rem_r;

  // next state
  always_comb begin
    mode_nxt      = mode_r;
    counted_nxt   = counted_r;
    lamp_nxt      = lamp_r;
    elapsed_nxt   = elapsed_r;
    pulse_len_nxt = pulse_len_r;
    on_len_nxt    = on_len_r;
    off_len_nxt   = off_len_r;
    rem_nxt       = rem_r;
    case (item.cmd)
      CMD_TICK: begin
        elapsed_nxt = el_inc;
        if (mode_r == MODE_PULSE) begin
          if (el_inc >= pulse_len_r) begin
            mode_nxt    = MODE_IDLE;
            counted_nxt = 1'b0;
            lamp_nxt    = 1'b0;
          end
        end else if (mode_r == MODE_BLINK) begin
          if (lamp_r && el_inc >= on_len_r) begin
            lamp_nxt    = 1'b0;
            elapsed_nxt = '0;
          end else if (!lamp_r && el_inc >= off_len_r) begin
            lamp_nxt    = 1'b1;
            elapsed_nxt = '0;
            if (counted_r) begin
              rem_nxt = rem_dec;
              if (rem_dec == '0) begin
                mode_nxt    = MODE_IDLE;
                counted_nxt = 1'b0;
                lamp_nxt    = 1'b0;
              end
            end
          end
        end
      end
      CMD_ON, CMD_OFF: begin
        mode_nxt    = MODE_FIXED;
        counted_nxt = 1'b0;
        rem_nxt     = '0;
        lamp_nxt    = (item.cmd == CMD_ON);
      end
      CMD_OFF_BLINK: begin
        if (mode_r == MODE_BLINK) begin
          mode_nxt    = MODE_FIXED;
          counted_nxt = 1'b0;
          rem_nxt     = '0;
          lamp_nxt    = 1'b0;
        end
      end
      CMD_PULSE: begin
        if (mode_r != MODE_PULSE) begin
          mode_nxt      = MODE_PULSE;
          counted_nxt   = 1'b0;
          rem_nxt       = '0;
          pulse_len_nxt = item.time_a;
          elapsed_nxt   = '0;
          lamp_nxt      = 1'b1;
        end
      end
      CMD_BLINK, CMD_BLINK_DUTY: begin
        if (mode_r != MODE_BLINK) begin
          mode_nxt    = MODE_BLINK;
          counted_nxt = (item.cyc != '0);
          rem_nxt     = item.cyc;
          on_len_nxt  = item.on_t;
          off_len_nxt = item.off_t;
          elapsed_nxt = '0;
          lamp_nxt    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result fields
  always_comb begin
    pin_nxt   = lamp_nxt ? active_level : !active_level;
    lit_nxt   = lamp_nxt;
    omode_nxt = mode_nxt;
    ocyc_nxt  = counted_nxt ? rem_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      counted_r   <= 1'b0;
      lamp_r      <= 1'b0;
      elapsed_r   <= '0;
      pulse_len_r <= '0;
      on_len_r    <= '0;
      off_len_r   <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        mode_r      <= mode_nxt;
        counted_r   <= counted_nxt;
        lamp_r      <= lamp_nxt;
        elapsed_r   <= elapsed_nxt;
        pulse_len_r <= pulse_len_nxt;
        on_len_r    <= on_len_nxt;
        off_len_r   <= off_len_nxt;
        rem_r       <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pin_r   <= pin_nxt;
      lit_r   <= lit_nxt;
      omode_r <= omode_nxt;
      ocyc_r  <= ocyc_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pin_level   = pin_r;
  assign out_lit         = lit_r;
  assign out_mode        = omode_r;
  assign out_cycles_left = ocyc_r;

endmodule

### hdl/led_blink_pulse_controller_core.sv
// top level of the single led blink / pulse controller
// depends on lbpc_pkg, lbpc_prep, lbpc_core and assert_macros.svh
`timescale 1ns / 1ps

// Each input transaction is a 1 ms tick (cmd 0) or a command: fixed on, fixed
// off, off if blinking, timed pulse, blink with on/off times, or blink from a
// period and a Q16 duty. Every transaction yields exactly one result with the
// pin level, the logical lamp state, the mode and the counted blink cycles
// still to run. A new transaction is taken every clock cycle; it passes three
// registers (input register, duty multiply register, state/result register)
// before its result shows on the outputs. The stages only hold when out_stall
// backs up into them. cfg_wr_en writes active_level (reset 1, active high);
// write it only when no transaction is in flight.

`include "assert_macros.svh"

module led_blink_pulse_controller_core import lbpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_time_a,
  input  logic [31:0] in_time_b,
  input  logic [6:0]  in_cycle_count,
  input  logic [16:0] in_duty,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pin_level,
  output logic        out_lit,
  output logic [1:0]  out_mode,
  output logic [6:0]  out_cycles_left
);

  logic  active_level_r, active_level_nxt;
  logic  item_valid;
  logic  item_ready;
  item_t item;

  // polarity register, one bit
  assign active_level_nxt = cfg_wr_en ? cfg_wr_data : active_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r <= 1'b1;
    end else begin
      active_level_r <= active_level_nxt;
    end
  end

  // input register and duty multiply
  lbpc_prep u_prep (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_time_a      (in_time_a),
    .in_time_b      (in_time_b),
    .in_cycle_count (in_cycle_count),
    .in_duty        (in_duty),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item)
  );

  // mode, lamp and timers, then the result register
  lbpc_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .active_level    (active_level_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pin_level   (out_pin_level),
    .out_lit         (out_lit),
    .out_mode        (out_mode),
    .out_cycles_left (out_cycles_left)
  );

  // counted cycles only ever show while blinking
  `LBPC_ASSERT_IMP(a_cyc_only_blink, out_valid && out_cycles_left != '0, out_mode == MODE_BLINK, "cycles left outside blink mode")
  // idle always means the lamp is dark
  `LBPC_ASSERT_IMP(a_idle_dark, out_valid && out_mode == MODE_IDLE, !out_lit, "lamp lit while idle")
  // a running pulse keeps the lamp lit
  `LBPC_ASSERT_IMP(a_pulse_lit, out_valid && out_mode == MODE_PULSE, out_lit, "lamp dark during pulse")

endmodule
